FILE: design/pgf_pkg.sv
`timescale 1ns / 1ps

package pgf_pkg;

  localparam int WIDTH       = 128;
  localparam int HEIGHT      = 128;
  localparam int MAX_GRAY    = 15;
  localparam int HALF_WIDTH  = (WIDTH + 1) / 2;
  localparam int STORE_BYTES = HALF_WIDTH * HEIGHT;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int CALC_W      = 32;

  localparam logic [7:0] LOW_NIBBLE  = 8'h0F;
  localparam logic [7:0] HIGH_NIBBLE = 8'hF0;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    KIND_DRAW  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_RMW,
    S_READ
  } state_t;

  // decoded input beat
  typedef struct packed {
    logic [1:0] kind;
    logic       in_frame;
    addr_t      pix_addr;
    logic       odd;
    logic [3:0] nib;
    logic [7:0] fill;
    logic       idx_ok;
    addr_t      idx_addr;
  } cmd_t;

  typedef struct packed {
    logic       wr_en;
    addr_t      wr_addr;
    logic [7:0] wr_data;
    logic       rd_en;
    addr_t      rd_addr;
  } mem_req_t;

endpackage

FILE: design/pgf_if.sv
`timescale 1ns / 1ps

interface pgf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic [7:0]         gray;
  logic [12:0]        byte_index;

  modport source (output valid, kind, pixel_x, pixel_y, gray, byte_index, input ready);
  modport sink   (input valid, kind, pixel_x, pixel_y, gray, byte_index, output ready);
endinterface

interface pgf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;

  modport source (output valid, read_byte, input ready);
  modport sink   (input valid, read_byte, output ready);
endinterface

FILE: design/pgf_store.sv
`timescale 1ns / 1ps

module pgf_store (
  input  logic              clk,
  input  pgf_pkg::mem_req_t req,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [pgf_pkg::STORE_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/pgf_ctrl.sv
`timescale 1ns / 1ps

module pgf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pgf_pkg::cmd_t     cmd,
  input  logic [7:0]        rd_data,
  output pgf_pkg::mem_req_t mem_req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_data
);

  pgf_pkg::state_t state_r, state_nxt;
  pgf_pkg::addr_t  cnt_r, cnt_nxt;
  pgf_pkg::addr_t  addr_r, addr_nxt;
  logic [7:0]      fill_r, fill_nxt;
  logic            odd_r, odd_nxt;
  logic [3:0]      nib_r, nib_nxt;
  logic            zero_r, zero_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_data_r, out_data_nxt;
  logic            slot_free;

  localparam pgf_pkg::addr_t LAST_ADDR = pgf_pkg::ADDR_W'(pgf_pkg::STORE_BYTES - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pgf_pkg::S_SWEEP;
      cnt_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    odd_r      <= odd_nxt;
    nib_r      <= nib_nxt;
    zero_r     <= zero_nxt;
    out_data_r <= out_data_nxt;
  end

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    addr_nxt      = addr_r;
    odd_nxt       = odd_r;
    nib_nxt       = nib_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    mem_req       = '0;

    unique case (state_r)
      pgf_pkg::S_SWEEP: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = cnt_r;
        mem_req.wr_data = fill_r;
        if (cnt_r == LAST_ADDR) begin
          state_nxt = pgf_pkg::S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      pgf_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (cmd.kind)
            pgf_pkg::KIND_DRAW: begin
              if (cmd.in_frame) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = cmd.pix_addr;
                addr_nxt        = cmd.pix_addr;
                odd_nxt         = cmd.odd;
                nib_nxt         = cmd.nib;
                state_nxt       = pgf_pkg::S_RMW;
              end
            end
            pgf_pkg::KIND_CLEAR: begin
              cnt_nxt   = '0;
              fill_nxt  = cmd.fill;
              state_nxt = pgf_pkg::S_SWEEP;
            end
            pgf_pkg::KIND_READ: begin
              mem_req.rd_en   = cmd.idx_ok;
              mem_req.rd_addr = cmd.idx_addr;
              zero_nxt        = !cmd.idx_ok;
              state_nxt       = pgf_pkg::S_READ;
            end
            default: begin
              // unused kind: beat taken, nothing done
            end
          endcase
        end
      end
      pgf_pkg::S_RMW: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = addr_r;
        if (odd_r) begin
          mem_req.wr_data = (rd_data & pgf_pkg::HIGH_NIBBLE) | {4'h0, nib_r};
        end else begin
          mem_req.wr_data = (rd_data & pgf_pkg::LOW_NIBBLE) | {nib_r, 4'h0};
        end
        state_nxt = pgf_pkg::S_IDLE;
      end
      pgf_pkg::S_READ: begin
        // read data stays in the RAM output register until the slot frees
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = zero_r ? 8'h00 : rd_data;
          state_nxt     = pgf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pgf_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pgf_pkg::S_IDLE) |-> !mem_req.wr_en)
    else $error("store written while idle");

  a_rise_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == pgf_pkg::S_READ))
    else $error("result raised outside read state");

  a_rmw_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pgf_pkg::S_RMW) |=> (state_r == pgf_pkg::S_IDLE))
    else $error("read-modify-write did not finish");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result lost");

endmodule

FILE: design/packed_gray_framebuffer.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Payload
// in_bus    in   valid / ready          kind, pixel_x, pixel_y, gray, byte_index
// out_bus   out  valid / ready          read_byte
//
// A draw reads the RAM, then modifies and writes back the byte; a read reads the RAM
// and then waits for the output register to free. Out-of-frame draws and unused
// kinds are taken without touching the RAM. Clear sweeps the RAM one byte a cycle.
// After reset the same sweep writes zero to every byte; no beat is taken then.
// A result waiting on out_bus does not stop draws or clears from being accepted.
module packed_gray_framebuffer (
  input logic     clk,
  input logic     rst_n,
  pgf_in_if.sink  in_bus,
  pgf_out_if.source out_bus
);

  pgf_pkg::cmd_t     cmd;
  pgf_pkg::mem_req_t mem_req;
  logic [7:0]        rd_data;

  logic [pgf_pkg::CALC_W-1:0] pix_full;
  logic [pgf_pkg::CALC_W-1:0] idx_full;
  logic [3:0]                 clamp;

  assign pix_full = pgf_pkg::CALC_W'(in_bus.pixel_y[9:0]) * pgf_pkg::CALC_W'(pgf_pkg::HALF_WIDTH)
                  + pgf_pkg::CALC_W'(in_bus.pixel_x[9:1]);
  assign idx_full = pgf_pkg::CALC_W'(in_bus.byte_index);

  always_comb begin
    if (in_bus.gray > 8'(pgf_pkg::MAX_GRAY)) begin
      clamp = 4'(pgf_pkg::MAX_GRAY);
    end else begin
      clamp = in_bus.gray[3:0];
    end
  end

  always_comb begin
    cmd.kind     = in_bus.kind;
    cmd.in_frame = !in_bus.pixel_x[15] && !in_bus.pixel_y[15]
                && ($unsigned(in_bus.pixel_x) < 16'(pgf_pkg::WIDTH))
                && ($unsigned(in_bus.pixel_y) < 16'(pgf_pkg::HEIGHT));
    cmd.pix_addr = pix_full[pgf_pkg::ADDR_W-1:0];
    cmd.odd      = in_bus.pixel_x[0];
    cmd.nib      = in_bus.gray[3:0];
    cmd.fill     = {clamp, clamp};
    cmd.idx_ok   = idx_full < pgf_pkg::CALC_W'(pgf_pkg::STORE_BYTES);
    cmd.idx_addr = idx_full[pgf_pkg::ADDR_W-1:0];
  end

  pgf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .cmd       (cmd),
    .rd_data   (rd_data),
    .mem_req   (mem_req),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_data  (out_bus.read_byte)
  );

  pgf_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule

FILE: tb/sv/pgf_shadow_checker.sv
`timescale 1ns / 1ps

module pgf_shadow_checker
  import pgf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pgf_in_if    in_bus,
  pgf_out_if   out_bus,
  output int   mismatch_count,
  output int   results_pending,
  output int   results_checked
);

  logic [7:0] shadow_store [STORE_BYTES];
  logic [7:0] pending_bytes [$];
  int         errs;
  int         checked;

  // Apply one accepted input beat to the shadow frame store.
  function automatic void update_shadow_store(logic [1:0] kind, int x, int y,
                                              logic [7:0] gray, logic [12:0] idx);
    int         addr;
    int         shade;
    logic [7:0] cur;
    logic [7:0] fill;
    case (kind)
      KIND_DRAW: begin
        if (x >= 0 && x < WIDTH && y >= 0 && y < HEIGHT) begin
          addr = y * HALF_WIDTH + x / 2;
          cur  = shadow_store[addr];
          if (x % 2 == 1) cur = {cur[7:4], gray[3:0]};
          else            cur = {gray[3:0], cur[3:0]};
          shadow_store[addr] = cur;
        end
      end
      KIND_CLEAR: begin
        shade = (int'(gray) > MAX_GRAY) ? MAX_GRAY : int'(gray);
        fill  = 8'((shade << 4) | shade);
        foreach (shadow_store[i]) shadow_store[i] = fill;
      end
      KIND_READ: begin
        if (int'(idx) < STORE_BYTES) pending_bytes.push_back(shadow_store[idx]);
        else                         pending_bytes.push_back(8'h00);
      end
      default: ;  // unused kind: no effect
    endcase
  endfunction

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst_n) begin
      foreach (shadow_store[i]) shadow_store[i] = 8'h00;
      pending_bytes.delete();
      errs    = 0;
      checked = 0;
    end else begin
      // result beats first; a read cannot complete on its own accept edge
      if (out_bus.valid && out_bus.ready) begin
        checked++;
        if (pending_bytes.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("[%0t] unexpected read beat: got %02h", $realtime, out_bus.read_byte);
        end else begin
          want = pending_bytes.pop_front();
          if (out_bus.read_byte !== want) begin
            errs++;
            if (errs <= 10)
              $display("[%0t] read_byte mismatch: expected %02h got %02h",
                       $realtime, want, out_bus.read_byte);
          end
        end
      end
      if (in_bus.valid && in_bus.ready)
        update_shadow_store(in_bus.kind, int'(in_bus.pixel_x), int'(in_bus.pixel_y),
                            in_bus.gray, in_bus.byte_index);
    end
    mismatch_count  <= errs;
    results_pending <= pending_bytes.size();
    results_checked <= checked;
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pgf_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 40000;  // longer than a reset sweep or a clear
  localparam int ITEM_GOAL   = 1850;

  logic clk;
  logic rst_n;
  bit   steady;

  int mismatch_count;
  int results_pending;
  int results_checked;

  int n_draw, n_clear, n_read, n_unused;
  int recent_addr [$];

  pgf_in_if  in_bus ();
  pgf_out_if out_bus ();

  packed_gray_framebuffer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  pgf_shadow_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_bus         (in_bus),
    .out_bus        (out_bus),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending),
    .results_checked(results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none during steady stretches
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 90);
  endfunction

  // result side backpressure
  initial begin
    int hold;
    hold = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  task automatic send_beat(input logic [1:0] kind, input int x, input int y,
                           input int gray, input int idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.kind       <= kind;
    in_bus.pixel_x    <= x[15:0];
    in_bus.pixel_y    <= y[15:0];
    in_bus.gray       <= gray[7:0];
    in_bus.byte_index <= idx[12:0];
    do @(posedge clk); while (!in_bus.ready);
    case (kind)
      KIND_DRAW:  n_draw++;
      KIND_CLEAR: n_clear++;
      KIND_READ:  n_read++;
      default:    n_unused++;
    endcase
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  task automatic draw_inside(input int x, input int y, input int gray);
    recent_addr.push_back(y * HALF_WIDTH + x / 2);
    if (recent_addr.size() > 24) void'(recent_addr.pop_front());
    send_beat(KIND_DRAW, x, y, gray, $urandom_range(0, 8191));
  endtask

  initial begin
    int done_items;
    int beat_no;
    int r;
    int x;
    int y;
    int idx;
    done_items = 0;
    beat_no    = 0;
    steady     = 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.kind       <= KIND_DRAW;
    in_bus.pixel_x    <= '0;
    in_bus.pixel_y    <= '0;
    in_bus.gray       <= '0;
    in_bus.byte_index <= '0;
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: cleared store, both nibbles, corners, out-of-frame, unused kind, clears
    send_beat(KIND_READ, 0, 0, 0, 0);
    send_beat(KIND_READ, 0, 0, 0, 8191);
    send_beat(KIND_DRAW, 0, 0, 8'hFF, 0);
    send_beat(KIND_DRAW, 1, 0, 8'hA5, 8191);
    send_beat(KIND_READ, 127, 127, 0, 0);
    send_beat(KIND_DRAW, WIDTH - 1, HEIGHT - 1, 8'h03, 0);
    send_beat(KIND_READ, 0, 0, 0, STORE_BYTES - 1);
    send_beat(KIND_DRAW, -1, 0, 8'hFF, 0);
    send_beat(KIND_DRAW, WIDTH, 0, 8'hFF, 0);
    send_beat(KIND_DRAW, 0, -1, 8'hFF, 0);
    send_beat(KIND_DRAW, 0, HEIGHT, 8'hFF, 0);
    send_beat(KIND_DRAW, -32768, 32767, 8'hFF, 0);
    send_beat(KIND_DRAW, 32767, -32768, 8'hFF, 0);
    send_beat(KIND_UNUSED, 4, 0, 8'hFF, 0);
    send_beat(KIND_READ, 0, 0, 0, 0);
    send_beat(KIND_READ, 0, 0, 0, 2);
    send_beat(KIND_READ, 0, 0, 0, HALF_WIDTH - 1);
    send_beat(KIND_CLEAR, 0, 0, 8'h07, 0);
    send_beat(KIND_READ, 0, 0, 0, 100);
    send_beat(KIND_CLEAR, 0, 0, 8'h10, 0);  // above max gray, clamps
    send_beat(KIND_DRAW, 2, 1, 8'hF0, 0);
    send_beat(KIND_READ, 0, 0, 0, HALF_WIDTH + 1);
    send_beat(KIND_CLEAR, 0, 0, 8'h00, 0);
    send_beat(KIND_READ, 0, 0, 0, 8191);

    while (done_items < ITEM_GOAL) begin
      beat_no++;
      steady = (beat_no % 300) < 70;
      if (beat_no % 250 == 0) drain_results();
      r = $urandom_range(0, 999);
      if (r < 8) begin
        send_beat(KIND_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 65535),
                  ($urandom_range(0, 1) != 0) ? $urandom_range(0, 15) : $urandom_range(0, 255),
                  $urandom_range(0, 8191));
        done_items++;
      end else if (r < 30) begin
        send_beat(KIND_UNUSED, $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 255), $urandom_range(0, 8191));
      end else if (r < 110) begin
        case ($urandom_range(0, 3))
          0: begin x = -1;    y = $urandom_range(0, HEIGHT - 1); end
          1: begin x = WIDTH; y = $urandom_range(0, HEIGHT - 1); end
          2: begin x = $urandom_range(0, WIDTH - 1); y = ($urandom_range(0, 1) != 0) ? -1 : HEIGHT; end
          default: begin x = $urandom_range(0, 65535); y = $urandom_range(0, 65535); end
        endcase
        send_beat(KIND_DRAW, x, y, $urandom_range(0, 255), $urandom_range(0, 8191));
        done_items++;
      end else if (r < 560) begin
        // half the draws stay in a corner so both nibbles of a byte get rewritten
        if ($urandom_range(0, 1) != 0) begin
          x = $urandom_range(0, 7);
          y = $urandom_range(0, 3);
        end else begin
          x = $urandom_range(0, WIDTH - 1);
          y = $urandom_range(0, HEIGHT - 1);
        end
        draw_inside(x, y, $urandom_range(0, 255));
        done_items++;
      end else begin
        if (recent_addr.size() > 0 && $urandom_range(0, 9) < 7)
          idx = recent_addr[$urandom_range(0, recent_addr.size() - 1)];
        else
          idx = $urandom_range(0, 8191);
        send_beat(KIND_READ, $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 255), idx);
        done_items++;
      end
    end

    steady = 1'b0;
    drain_results();
    repeat (50) @(posedge clk);

    $display("Covered %0d draws, %0d clears, %0d reads and %0d unused-kind beats",
             n_draw, n_clear, n_read, n_unused);
    $display("Checked %0d read results under random gaps, steady runs and drain pauses",
             results_checked);
    if (results_pending != 0)
      $display("%0d read results never arrived", results_pending);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog: cycles with no beat on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
